@@ hw/rtl/bal_pkg.sv @@
// ----------------------------------------------------------------------------
// bal_pkg: shared types for the bounded array list
// Operation codes, cell command modes, the cell control bundle and the
// sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package bal_pkg;

   localparam int DATA_W = 32;
   localparam int POS_W  = 8;

   typedef enum logic [2:0] {
      ACT_INS_FRONT = 3'd0,
      ACT_INS_BACK  = 3'd1,
      ACT_INS_AT    = 3'd2,
      ACT_REM_FRONT = 3'd3,
      ACT_REM_BACK  = 3'd4,
      ACT_REM_AT    = 3'd5,
      ACT_FIND      = 3'd6,
      ACT_ROTATE    = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      MODE_HOLD   = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_ROTATE = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type             mode;
      logic [POS_W-1:0]     pos;
      logic [POS_W-1:0]     fill;
      logic [DATA_W-1:0]    value;
   } cell_ctl_type;

   typedef enum logic [0:0] {
      ST_IDLE   = 1'b0,
      ST_ROTATE = 1'b1
   } state_type;

endpackage

`default_nettype wire

@@ hw/rtl/bal_cell.sv @@
// ----------------------------------------------------------------------------
// bal_cell: one list slot
// Holds one entry and moves data from its left or right neighbor, or loads
// the broadcast value, as the shared command and its own index decide.
// ----------------------------------------------------------------------------
`default_nettype none

module bal_cell
   import bal_pkg::*;
#(
   parameter int IDX = 0
) (
   input  wire logic              clock,
   input  wire cell_ctl_type      ctl,
   input  wire logic [DATA_W-1:0] left_data,
   input  wire logic [DATA_W-1:0] right_data,
   output logic [DATA_W-1:0]      entry
);

   localparam logic [POS_W-1:0] IDX_V  = POS_W'(IDX);
   localparam logic [POS_W-1:0] IDX_N  = POS_W'(IDX + 1);

   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.mode)
         MODE_INSERT: begin
            if (IDX_V == ctl.pos) begin
               entry_in = ctl.value;
            end else if (IDX_V > ctl.pos && IDX_V <= ctl.fill) begin
               entry_in = left_data;
            end
         end
         MODE_REMOVE: begin
            if (IDX_V >= ctl.pos && IDX_N < ctl.fill) begin
               entry_in = right_data;
            end
         end
         MODE_ROTATE: begin
            // cell zero gets the wrap entry on its left input
            if (IDX_V < ctl.fill) begin
               entry_in = left_data;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

@@ hw/rtl/bounded_array_list_unit.sv @@
// inserts, removes and finds answer in the cycle after the transfer
// rotate: amount is first reduced by subtracting the count once per cycle,
//   then the occupied cells shift right one place per cycle, and a last step loads the answer
// throughput: one item per cycle while answers are taken, except rotate; the rotate sequencer sets it
// reset: synchronous, clears count, sequencer and result valid; entries are
//   left as they are and never read before written
// ----------------------------------------------------------------------------
// bounded_array_list_unit: bounded ordered list of signed entries
// A row of cells holds the entries; a sequencer issues one shared command per
// cycle and keeps the fill count and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_array_list_unit
   import bal_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [2:0]                 req_action,
   input  wire logic signed [DATA_W-1:0]   req_value,
   input  wire logic [POS_W-1:0]           req_position,
   input  wire logic [POS_W-1:0]           req_amount,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_ok,
   output logic signed [DATA_W-1:0]        rsp_removed_value,
   output logic [$clog2(DEPTH)-1:0]        rsp_found_index,
   output logic [$clog2(DEPTH+1)-1:0]      rsp_count
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   state_type           state_ff, state_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [POS_W-1:0]    rot_left_ff, rot_left_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [DATA_W-1:0]   rsp_removed_ff, rsp_removed_in;
   logic [IW-1:0]       rsp_found_ff, rsp_found_in;
   logic [CW-1:0]       rsp_count_ff, rsp_count_in;

   logic                rsp_load;
   logic                accept;
   logic                rot_start;
   logic                rot_done;
   cell_ctl_type        ctl;
   logic [DATA_W-1:0]   entry_data [DEPTH];
   logic [DATA_W-1:0]   wrap_data;
   logic [CW-1:0]       fill_m1;
   logic [POS_W-1:0]    fill8;
   logic [POS_W-1:0]    rem_pos;
   logic [DEPTH-1:0]    hit;
   logic                any_hit;
   logic [IW-1:0]       hit_idx;
   action_type          action;

   assign action    = action_type'(req_action);
   assign fill8     = POS_W'(fill_ff);
   assign fill_m1   = fill_ff - CW'(1);
   assign wrap_data = entry_data[fill_m1[IW-1:0]];
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // row of cells
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_W-1:0] left_w;
      logic [DATA_W-1:0] right_w;
      if (g == 0) begin : g_first
         assign left_w = wrap_data;
      end else begin : g_mid
         assign left_w = entry_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_w = entry_data[g];
      end else begin : g_inner
         assign right_w = entry_data[g+1];
      end
      bal_cell #(
         .IDX (g)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .left_data  (left_w),
         .right_data (right_w),
         .entry      (entry_data[g])
      );
      assign hit[g] = (entry_data[g] == $unsigned(req_value)) && (POS_W'(g) < fill8);
   end

   // first matching index
   always_comb begin
      hit_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (hit[i]) begin
            hit_idx = IW'(i);
         end
      end
   end
   assign any_hit = |hit;

   assign rot_start = accept && (action == ACT_ROTATE) && (fill_ff != '0);
   assign rot_done  = (state_ff == ST_ROTATE) && (rot_left_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (rot_start) state_in = ST_ROTATE;
         ST_ROTATE: if (rot_done) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // commands and result
   always_comb begin
      ctl            = '{mode: MODE_HOLD, pos: '0, fill: fill8, value: $unsigned(req_value)};
      fill_in        = fill_ff;
      rot_left_in    = rot_left_ff;
      rsp_load       = 1'b0;
      rsp_ok_in      = 1'b0;
      rsp_removed_in = '0;
      rsp_found_in   = '0;
      rem_pos        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_load = 1'b1;
               unique case (action)
                  ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
                     if (action == ACT_INS_BACK) begin
                        ctl.pos = fill8;
                     end else if (action == ACT_INS_AT) begin
                        ctl.pos = req_position;
                     end
                     if (fill_ff != FULL &&
                         (action != ACT_INS_AT || req_position < fill8)) begin
                        ctl.mode  = MODE_INSERT;
                        fill_in   = fill_ff + CW'(1);
                        rsp_ok_in = 1'b1;
                     end
                  end
                  ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_AT: begin
                     if (action == ACT_REM_BACK) begin
                        rem_pos = POS_W'(fill_m1);
                     end else if (action == ACT_REM_AT) begin
                        rem_pos = req_position;
                     end
                     ctl.pos = rem_pos;
                     if (rem_pos < fill8) begin
                        ctl.mode       = MODE_REMOVE;
                        fill_in        = fill_m1;
                        rsp_ok_in      = 1'b1;
                        rsp_removed_in = entry_data[rem_pos[IW-1:0]];
                     end
                  end
                  ACT_FIND: begin
                     rsp_ok_in = any_hit;
                     if (any_hit) begin
                        rsp_found_in = hit_idx;
                     end
                  end
                  ACT_ROTATE: begin
                     rsp_ok_in = 1'b1;
                     if (fill_ff != '0) begin
                        rsp_load    = 1'b0;
                        rot_left_in = req_amount;
                     end
                  end
                  default: rsp_load = 1'b1;
               endcase
            end
         end
         ST_ROTATE: begin
            if (rot_left_ff >= fill8) begin
               rot_left_in = rot_left_ff - fill8;
            end else if (rot_left_ff != '0) begin
               ctl.mode    = MODE_ROTATE;
               rot_left_in = rot_left_ff - POS_W'(1);
            end else begin
               rsp_load  = 1'b1;
               rsp_ok_in = 1'b1;
            end
         end
         default: rsp_load = 1'b0;
      endcase
      rsp_count_in = fill_in;
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rot_left_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rot_left_ff  <= rot_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ok_ff      <= rsp_ok_in;
         rsp_removed_ff <= rsp_removed_in;
         rsp_found_ff   <= rsp_found_in;
         rsp_count_ff   <= rsp_count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_removed_value = $signed(rsp_removed_ff);
   assign rsp_found_index   = rsp_found_ff;
   assign rsp_count         = rsp_count_ff;

endmodule

`default_nettype wire

@@ tb/tb_bounded_array_list_unit.sv @@
// ----------------------------------------------------------------------------
// tb_bounded_array_list_unit: self-checking bench for the bounded array list
// A queue of list operations feeds a valid/ready driver; an in-bench copy of
// the list predicts each answer at the request transfer, and a monitor
// compares every answer field by field. Directed cases cover empty, full and
// out-of-range operations, then random traffic with random stalls on both
// sides, one long answer back-pressure stretch and two full drain pauses.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bounded_array_list_unit;
   import bal_pkg::*;

   localparam int DEPTH       = 8;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int RANDOM_OPS  = 1250;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      action_type               action;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
      logic [POS_W-1:0]         amount;
      bit                       drain_first;
   } list_op_type;

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] removed;
      logic [IDX_W-1:0]         found_index;
      logic [CNT_W-1:0]         count;
   } list_answer_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [2:0]               req_action = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic [POS_W-1:0]         req_amount = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_ok;
   logic signed [DATA_W-1:0] rsp_removed_value;
   logic [IDX_W-1:0]         rsp_found_index;
   logic [CNT_W-1:0]         rsp_count;

   list_op_type     op_queue[$];
   list_answer_type answer_queue[$];
   list_op_type     cur_op;

   logic signed [DATA_W-1:0] list_store [DEPTH];
   int unsigned              list_fill = 0;

   int unsigned ops_accepted = 0;
   int unsigned answers_checked = 0;
   int unsigned idle_left = 0;
   int unsigned hold_left = 0;
   bit          long_hold_done = 1'b0;
   int unsigned errors = 0;
   int unsigned cycles = 0;

   // stimulus-side shadow used only to shape positions and find values
   int unsigned              gen_fill = 0;
   logic signed [DATA_W-1:0] recent_values [8];
   int unsigned              recent_wr = 0;

   bounded_array_list_unit #(.DEPTH(DEPTH)) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_value         (req_value),
      .req_position      (req_position),
      .req_amount        (req_amount),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ok            (rsp_ok),
      .rsp_removed_value (rsp_removed_value),
      .rsp_found_index   (rsp_found_index),
      .rsp_count         (rsp_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic list_answer_type apply_list_op(input list_op_type op);
      list_answer_type          ans;
      logic signed [DATA_W-1:0] spun [DEPTH];
      int unsigned              slot;
      int unsigned              k;
      int                       i;
      ans = '0;
      slot = 0;
      case (op.action)
         ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
            if (list_fill < DEPTH && (op.action != ACT_INS_AT || op.position < list_fill)) begin
               if (op.action == ACT_INS_BACK) slot = list_fill;
               else if (op.action == ACT_INS_AT) slot = op.position;
               for (i = list_fill; i > int'(slot); i--) list_store[i] = list_store[i-1];
               list_store[slot] = op.value;
               list_fill++;
               ans.ok = 1'b1;
            end
         end
         ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_AT: begin
            if (list_fill > 0 && (op.action != ACT_REM_AT || op.position < list_fill)) begin
               if (op.action == ACT_REM_BACK) slot = list_fill - 1;
               else if (op.action == ACT_REM_AT) slot = op.position;
               ans.removed = list_store[slot];
               for (i = slot; i + 1 < int'(list_fill); i++) list_store[i] = list_store[i+1];
               list_fill--;
               ans.ok = 1'b1;
            end
         end
         ACT_FIND: begin
            for (i = 0; i < int'(list_fill); i++) begin
               if (!ans.ok && list_store[i] == op.value) begin
                  ans.ok = 1'b1;
                  ans.found_index = IDX_W'(i);
               end
            end
         end
         default: begin
            ans.ok = 1'b1;
            if (list_fill != 0) begin
               k = op.amount % list_fill;
               if (k != 0) begin
                  for (i = 0; i < int'(list_fill); i++) spun[(i + k) % list_fill] = list_store[i];
                  for (i = 0; i < int'(list_fill); i++) list_store[i] = spun[i];
               end
            end
         end
      endcase
      ans.count = CNT_W'(list_fill);
      return ans;
   endfunction

   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 4) == 0) return $urandom_range(10, 30);
      return $urandom_range(1, 3);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at answer %0d: %s", answers_checked, msg);
      errors++;
   endtask

   task automatic queue_op(input action_type act, input logic signed [DATA_W-1:0] val,
                           input int unsigned pos, input int unsigned amt,
                           input bit drain = 1'b0);
      list_op_type op;
      op.action = act;
      op.value = val;
      op.position = POS_W'(pos);
      op.amount = POS_W'(amt);
      op.drain_first = drain;
      op_queue.push_back(op);
      case (act)
         ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
            if (gen_fill < DEPTH && (act != ACT_INS_AT || op.position < gen_fill)) begin
               gen_fill++;
               recent_values[recent_wr % 8] = val;
               recent_wr++;
            end
         end
         ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_AT: begin
            if (gen_fill > 0 && (act != ACT_REM_AT || op.position < gen_fill)) gen_fill--;
         end
         default: ;
      endcase
   endtask

   // driver: one pending operation per transfer, random gaps between them
   always @(posedge clock) begin : drive_ops
      int unsigned accepted_now;
      bit          quiet;
      accepted_now = ops_accepted;
      quiet = ((ops_accepted / 128) % 4) == 2;
      if (reset) begin
         req_valid <= 1'b0;
         idle_left <= 0;
      end else begin
         if (req_valid && req_ready) begin
            answer_queue.push_back(apply_list_op(cur_op));
            accepted_now++;
            ops_accepted <= accepted_now;
         end
         if (!req_valid || req_ready) begin
            if (idle_left != 0) begin
               idle_left <= idle_left - 1;
               req_valid <= 1'b0;
            end else if (op_queue.size() == 0 ||
                         (op_queue[0].drain_first && accepted_now != answers_checked)) begin
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
               idle_left <= pick_gap() - 1;
               req_valid <= 1'b0;
            end else begin
               cur_op = op_queue.pop_front();
               req_valid <= 1'b1;
               req_action <= cur_op.action;
               req_value <= cur_op.value;
               req_position <= cur_op.position;
               req_amount <= cur_op.amount;
            end
         end
      end
   end

   // answer side ready: random stalls plus one long hold-off
   always @(posedge clock) begin : drive_ready
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!long_hold_done && answers_checked >= 300) begin
         long_hold_done <= 1'b1;
         hold_left <= 80;
         rsp_ready <= 1'b0;
      end else if (((answers_checked / 128) % 4) == 2) begin
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         hold_left <= pick_gap() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_answers
      list_answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (answer_queue.size() == 0) begin
            report_mismatch("answer transfer with nothing pending");
         end else begin
            want = answer_queue.pop_front();
            if (rsp_ok !== want.ok)
               report_mismatch($sformatf("ok got %0b expected %0b", rsp_ok, want.ok));
            if (rsp_removed_value !== want.removed)
               report_mismatch($sformatf("removed_value got %0d expected %0d",
                                         rsp_removed_value, want.removed));
            if (rsp_found_index !== want.found_index)
               report_mismatch($sformatf("found_index got %0d expected %0d",
                                         rsp_found_index, want.found_index));
            if (rsp_count !== want.count)
               report_mismatch($sformatf("count got %0d expected %0d", rsp_count, want.count));
            answers_checked <= answers_checked + 1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : run_test
      int                       n;
      action_type               act;
      logic signed [DATA_W-1:0] val;
      int unsigned              pos;
      int unsigned              amt;
      int unsigned              roll;

      // empty list
      queue_op(ACT_REM_FRONT, 0, 0, 0);
      queue_op(ACT_REM_BACK, 0, 0, 0);
      queue_op(ACT_REM_AT, 0, 0, 0);
      queue_op(ACT_INS_AT, 5, 0, 0);
      queue_op(ACT_FIND, 0, 0, 0);
      queue_op(ACT_ROTATE, 0, 0, 255);
      // build up, extremes and position equal to count
      queue_op(ACT_INS_BACK, 32'sh7fffffff, 0, 0);
      queue_op(ACT_INS_FRONT, 32'sh80000000, 0, 0);
      queue_op(ACT_INS_AT, -1, 1, 0);
      queue_op(ACT_INS_AT, 7, 3, 0);
      queue_op(ACT_INS_BACK, 0, 0, 0);
      queue_op(ACT_FIND, 0, 0, 0);
      queue_op(ACT_FIND, 12345, 0, 0);
      queue_op(ACT_ROTATE, 0, 0, 4);
      queue_op(ACT_ROTATE, 0, 0, 255);
      // fill to the top, then inserts on a full list
      queue_op(ACT_INS_BACK, -1, 0, 0);
      queue_op(ACT_INS_FRONT, 32'sh55555555, 0, 0);
      queue_op(ACT_INS_AT, 32'shaaaaaaaa, 5, 0);
      queue_op(ACT_INS_BACK, 1, 0, 0);
      queue_op(ACT_INS_FRONT, 2, 0, 0);
      queue_op(ACT_INS_AT, 3, 0, 0);
      // duplicate value, first index wins
      queue_op(ACT_FIND, -1, 0, 0);
      queue_op(ACT_REM_AT, 0, 7, 0);
      queue_op(ACT_REM_AT, 0, 7, 0);
      queue_op(ACT_REM_AT, 0, 255, 0);
      queue_op(ACT_REM_FRONT, 0, 0, 0);
      queue_op(ACT_REM_BACK, 0, 0, 0);

      for (n = 0; n < RANDOM_OPS; n++) begin
         act = action_type'(3'($urandom_range(0, 7)));
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            case ($urandom_range(0, 3))
               0: val = 32'sh80000000;
               1: val = 32'sh7fffffff;
               2: val = 0;
               default: val = -1;
            endcase
         end else if (roll < 40 && recent_wr != 0) begin
            val = recent_values[$urandom_range(0, 7) % (recent_wr < 8 ? recent_wr : 8)];
         end else begin
            val = $urandom;
         end
         if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 255);
         else pos = $urandom_range(0, gen_fill);
         if ($urandom_range(0, 7) == 0) amt = $urandom_range(0, 255);
         else amt = $urandom_range(0, 2 * DEPTH);
         queue_op(act, val, pos, amt, n == 0 || n == 700);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // sample between edges so the driver's updates have settled
      while (op_queue.size() != 0 || req_valid || ops_accepted != answers_checked)
         @(negedge clock);
      repeat (20) @(posedge clock);

      if (errors == 0 && answer_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
